/* hdl/heartbeat_led_pattern_generator_assert.svh */
// ---------------------------------------------------------------------------
// Heartbeat LED pattern generator assertion macros
// Implication checks on the same cycle and on the next cycle.
// ---------------------------------------------------------------------------
`ifndef HEARTBEAT_LED_PATTERN_GENERATOR_ASSERT_SVH
`define HEARTBEAT_LED_PATTERN_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)

`define ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/hbled_pkg.sv */
// ---------------------------------------------------------------------------
// Heartbeat LED package
// Shared constants, register indexes and the structs between the modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbled_pkg;

  localparam int FADE_WINDOWS_DEF  = 32;
  localparam int FLASH_WINDOWS_DEF = 32;
  localparam int TICK_HZ_DEF       = 1000;

  localparam int PERIOD_REG_W = 16;
  localparam int PERIOD_W     = 12;
  localparam int PERIOD_MIN   = 500;
  localparam int PERIOD_MAX   = 3000;
  localparam int PERIOD_RESET = 1000;
  localparam int MS_PER_S     = 1000;

  localparam int LEN_W     = 8;
  localparam int LEN_MAX   = 255;
  localparam int PATTERN_W = 32;
  localparam int INDEX_W   = 5;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int RC_W          = 2;
  localparam int RECALC_CYCLES = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BREATHE_MODE  = 2'd0,
    REG_FLASH_PATTERN = 2'd1,
    REG_PERIOD        = 2'd2,
    REG_ENABLE        = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                 breathe_mode;
    logic [PATTERN_W-1:0] flash_pattern;
    logic                 enable;
    logic [LEN_W-1:0]     window_length;
    logic                 restart;
    logic                 busy;
  } cfg_t;

  typedef struct packed {
    logic               led_level;
    logic [INDEX_W-1:0] window_index;
  } result_t;

endpackage

/* hdl/hbled_cfg.sv */
// ---------------------------------------------------------------------------
// Heartbeat LED configuration
// Register file plus a three-stage pipeline that derives the window length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbled_cfg import hbled_pkg::*; #(
  parameter int FADE_WINDOWS  = FADE_WINDOWS_DEF,
  parameter int FLASH_WINDOWS = FLASH_WINDOWS_DEF,
  parameter int TICK_HZ       = TICK_HZ_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  output cfg_t                   cfg
);

  localparam int WMAX     = (FADE_WINDOWS > FLASH_WINDOWS) ? FADE_WINDOWS : FLASH_WINDOWS;
  localparam int WIN_BITS = $clog2(WMAX);
  localparam int S1       = PERIOD_W + WIN_BITS;
  localparam int RQ_W     = S1 + 1;
  localparam longint unsigned RECIP_FADE =
    ((longint'(1) << S1) + FADE_WINDOWS - 1) / FADE_WINDOWS;
  localparam longint unsigned RECIP_FLASH =
    ((longint'(1) << S1) + FLASH_WINDOWS - 1) / FLASH_WINDOWS;
  localparam int QP_W = PERIOD_W + RQ_W;

  localparam int HZ_W = $clog2(TICK_HZ + 1);
  localparam int T_W  = PERIOD_W + HZ_W;
  localparam int S2   = T_W + $clog2(MS_PER_S);
  localparam longint unsigned RECIP_MS = ((longint'(1) << S2) + MS_PER_S - 1) / MS_PER_S;
  localparam int R2_W = $clog2(RECIP_MS + 1);
  localparam int LP_W = T_W + R2_W;
  localparam int QL_W = LP_W - S2;

  logic                    breathe_mode;
  logic [PATTERN_W-1:0]    flash_pattern;
  logic [PERIOD_REG_W-1:0] period_req;
  logic                    enable;
  logic                    restart;
  logic [RC_W-1:0]         recalc_count;
  logic                    index_known;

  logic [PERIOD_W-1:0] period_clamped;
  logic [RQ_W-1:0]     recip;
  logic [QP_W-1:0]     q_prod;
  logic [PERIOD_W-1:0] q_next;
  logic [PERIOD_W-1:0] quotient;
  logic [T_W-1:0]      ticks_next;
  logic [T_W-1:0]      ticks;
  logic [LP_W-1:0]     len_prod;
  logic [QL_W-1:0]     len_raw;
  logic [LEN_W-1:0]    window_length_next;
  logic [LEN_W-1:0]    window_length;

  always_comb begin
    case (cfg_index_t'(write_index))
      REG_BREATHE_MODE, REG_FLASH_PATTERN, REG_PERIOD, REG_ENABLE: begin
        index_known = 1'b1;
      end
      default: begin
        index_known = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breathe_mode  <= 1'b0;
      flash_pattern <= '0;
      period_req    <= PERIOD_REG_W'(PERIOD_RESET);
      enable        <= 1'b0;
      restart       <= 1'b0;
      recalc_count  <= RC_W'(RECALC_CYCLES);
    end else begin
      restart <= 1'b0;
      if (recalc_count != '0) begin
        recalc_count <= recalc_count - RC_W'(1);
      end
      if (write_enable) begin
        case (cfg_index_t'(write_index))
          REG_BREATHE_MODE:  breathe_mode  <= write_data[0];
          REG_FLASH_PATTERN: flash_pattern <= write_data[PATTERN_W-1:0];
          REG_PERIOD:        period_req    <= write_data[PERIOD_REG_W-1:0];
          REG_ENABLE:        enable        <= write_data[0];
          default: begin
          end
        endcase
        if (index_known) begin
          restart      <= 1'b1;
          recalc_count <= RC_W'(RECALC_CYCLES);
        end
      end
    end
  end

  // len = floor(TICK_HZ * floor(p / W) / 1000), both divisions by exact reciprocal
  always_comb begin
    if (period_req >= PERIOD_REG_W'(PERIOD_MAX)) begin
      period_clamped = PERIOD_W'(PERIOD_MAX);
    end else if (period_req <= PERIOD_REG_W'(PERIOD_MIN)) begin
      period_clamped = PERIOD_W'(PERIOD_MIN);
    end else begin
      period_clamped = period_req[PERIOD_W-1:0];
    end
    recip      = breathe_mode ? RQ_W'(RECIP_FADE) : RQ_W'(RECIP_FLASH);
    q_prod     = QP_W'(period_clamped) * QP_W'(recip);
    q_next     = q_prod[S1 +: PERIOD_W];
    ticks_next = T_W'(quotient) * T_W'(TICK_HZ);
    len_prod   = LP_W'(ticks) * LP_W'(RECIP_MS);
    len_raw    = len_prod[S2 +: QL_W];
    if (len_raw > QL_W'(LEN_MAX)) begin
      window_length_next = LEN_W'(LEN_MAX);
    end else begin
      window_length_next = len_raw[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quotient      <= q_next;
    ticks         <= ticks_next;
    window_length <= window_length_next;
  end

  assign cfg.breathe_mode  = breathe_mode;
  assign cfg.flash_pattern = flash_pattern;
  assign cfg.enable        = enable;
  assign cfg.window_length = window_length;
  assign cfg.restart       = restart;
  assign cfg.busy          = (recalc_count != '0);

endmodule

/* hdl/hbled_core.sv */
// ---------------------------------------------------------------------------
// Heartbeat LED core
// Input register, window and tick counters, PWM duty compare and pattern shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heartbeat_led_pattern_generator_assert.svh"

module hbled_core import hbled_pkg::*; #(
  parameter int FADE_WINDOWS  = FADE_WINDOWS_DEF,
  parameter int FLASH_WINDOWS = FLASH_WINDOWS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    advance,
  input  logic    out_ready,
  output logic    load,
  output result_t res
);

  localparam int WMAX   = (FADE_WINDOWS > FLASH_WINDOWS) ? FADE_WINDOWS : FLASH_WINDOWS;
  localparam int CNT_W  = $clog2(WMAX);
  localparam int DUTY_W = CNT_W + 10;
  localparam int TI_W   = LEN_W + 1;

  logic                 item_valid;
  logic                 item_advance;
  logic [LEN_W-1:0]     tick_in_window;
  logic [CNT_W-1:0]     window_counter;
  logic [PATTERN_W-1:0] pattern_shift;
  logic                 led_register;

  logic [LEN_W-1:0]     tick_in_window_next;
  logic [CNT_W-1:0]     window_counter_next;
  logic [PATTERN_W-1:0] pattern_shift_next;
  logic                 led_register_next;

  logic                 accept;
  logic                 step;
  logic [CNT_W:0]       win_count;
  logic [TI_W-1:0]      tick_inc;
  logic                 window_done;
  logic [CNT_W:0]       wc_inc;
  logic                 wc_wrap;
  logic [CNT_W-1:0]     wc_advanced;
  logic [CNT_W-1:0]     mirror;
  logic [CNT_W-1:0]     fold;
  logic [DUTY_W-1:0]    duty_lhs;
  logic [DUTY_W-1:0]    duty_rhs;
  logic                 breathe_led;
  logic [CNT_W+INDEX_W-1:0] index_ext;

  assign load     = item_valid & out_ready;
  assign in_stall = cfg.busy | (item_valid & ~out_ready);
  assign accept   = in_valid & ~in_stall;
  assign step     = load & cfg.enable & item_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (load) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_advance <= advance;
    end
  end

  // led on while (tick + 1) * W <= 2 * min(w, W-1-w) * len
  always_comb begin
    win_count   = cfg.breathe_mode ? (CNT_W+1)'(FADE_WINDOWS) : (CNT_W+1)'(FLASH_WINDOWS);
    tick_inc    = TI_W'(tick_in_window) + TI_W'(1);
    window_done = tick_inc >= TI_W'(cfg.window_length);
    wc_inc      = (CNT_W+1)'(window_counter) + (CNT_W+1)'(1);
    wc_wrap     = wc_inc >= win_count;
    wc_advanced = wc_wrap ? '0 : wc_inc[CNT_W-1:0];
    if ((CNT_W+1)'(window_counter) < (CNT_W+1)'(FADE_WINDOWS)) begin
      mirror = CNT_W'(FADE_WINDOWS - 1) - window_counter;
    end else begin
      mirror = '0;
    end
    fold        = (window_counter < mirror) ? window_counter : mirror;
    duty_lhs    = DUTY_W'(tick_inc) * DUTY_W'(FADE_WINDOWS);
    duty_rhs    = DUTY_W'({fold, 1'b0}) * DUTY_W'(cfg.window_length);
    breathe_led = duty_lhs <= duty_rhs;
  end

  always_comb begin
    tick_in_window_next = tick_in_window;
    window_counter_next = window_counter;
    pattern_shift_next  = pattern_shift;
    led_register_next   = led_register;
    if (cfg.restart) begin
      tick_in_window_next = '0;
      window_counter_next = '0;
      pattern_shift_next  = cfg.flash_pattern;
    end else if (step) begin
      tick_in_window_next = window_done ? '0 : tick_inc[LEN_W-1:0];
      if (cfg.breathe_mode) begin
        led_register_next = breathe_led;
        if (window_done) begin
          window_counter_next = wc_advanced;
        end
      end else if (window_done) begin
        led_register_next   = pattern_shift[0];
        window_counter_next = wc_advanced;
        pattern_shift_next  = wc_wrap ? cfg.flash_pattern : (pattern_shift >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_in_window <= '0;
      window_counter <= '0;
      pattern_shift  <= '0;
      led_register   <= 1'b0;
    end else begin
      tick_in_window <= tick_in_window_next;
      window_counter <= window_counter_next;
      pattern_shift  <= pattern_shift_next;
      led_register   <= led_register_next;
    end
  end

  assign index_ext        = (CNT_W+INDEX_W)'(window_counter_next);
  assign res.led_level    = led_register_next;
  assign res.window_index = index_ext[INDEX_W-1:0];

  `ASSERT_NXT(a_item_held, clk, rst, item_valid && !out_ready, item_valid)
  `ASSERT_NXT(a_restart_clears, clk, rst, cfg.restart, tick_in_window == '0 && window_counter == '0)
  `ASSERT_IMP(a_tick_in_range, clk, rst, !cfg.busy, tick_in_window < cfg.window_length || tick_in_window == '0)

endmodule

/* hdl/hbled_out.sv */
// ---------------------------------------------------------------------------
// Heartbeat LED result register
// Holds one result item until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbled_out import hbled_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  result_t            res,
  output logic               out_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               led_level,
  output logic [INDEX_W-1:0] window_index
);

  result_t result;

  assign out_ready = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

  assign led_level    = result.led_level;
  assign window_index = result.window_index;

endmodule

/* hdl/heartbeat_led_pattern_generator.sv */
// ---------------------------------------------------------------------------
// Heartbeat LED pattern generator
// Breathing PWM or bit-pattern flashing of an LED, advanced by tick items.
// ---------------------------------------------------------------------------
// An accepted item passes through the core input register into the result register.
// One item per cycle while no register write or out_stall holds it; results drain one per cycle.
// Window length comes from a 3-stage reciprocal-multiply pipeline; in_stall is
// held high after reset and after every register write while it settles.
// Reset (rst, synchronous): counters cleared, LED off, registers at defaults.
`timescale 1ns / 1ps

module heartbeat_led_pattern_generator import hbled_pkg::*; #(
  parameter int FADE_WINDOWS  = FADE_WINDOWS_DEF,
  parameter int FLASH_WINDOWS = FLASH_WINDOWS_DEF,
  parameter int TICK_HZ       = TICK_HZ_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   advance,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   led_level,
  output logic [INDEX_W-1:0]     window_index
);

  cfg_t    cfg;
  result_t res;
  logic    load;
  logic    out_ready;

  hbled_cfg #(
    .FADE_WINDOWS  (FADE_WINDOWS),
    .FLASH_WINDOWS (FLASH_WINDOWS),
    .TICK_HZ       (TICK_HZ)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  hbled_core #(
    .FADE_WINDOWS  (FADE_WINDOWS),
    .FLASH_WINDOWS (FLASH_WINDOWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .advance   (advance),
    .out_ready (out_ready),
    .load      (load),
    .res       (res)
  );

  hbled_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .res          (res),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_level    (led_level),
    .window_index (window_index)
  );

endmodule

/* dv/tb_heartbeat_led_pattern_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat LED pattern generator testbench
// Drives tick items through the valid/stall input, programs mode, pattern,
// period and enable between phases, and compares every LED result against
// an in-bench model of the breathing PWM and the pattern flasher.
// ----------------------------------------------------------------------------

module tb_heartbeat_led_pattern_generator import hbled_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD_AT   = 120;
  localparam int LONG_HOLD_LEN  = 90;

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] write_index  = REG_BREATHE_MODE;
  logic [CFG_DATA_W-1:0]  write_data   = '0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic                   advance      = 1'b0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic                   led_level;
  logic [INDEX_W-1:0]     window_index;

  heartbeat_led_pattern_generator dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_level    (led_level),
    .window_index (window_index)
  );

  // LED model state
  logic                 cfg_breathe;
  logic [PATTERN_W-1:0] cfg_pattern;
  logic [15:0]          cfg_period;
  logic                 cfg_enable;
  int unsigned          tick_count;
  int unsigned          win_count;
  int unsigned          win_len;
  logic [PATTERN_W-1:0] shift_q;
  logic                 led_q;

  bit      tick_queue[$];
  result_t expected_leds[$];

  logic in_accepted = 1'b0;
  logic out_taken   = 1'b0;
  int   send_gap    = 0;
  bit   send_fast   = 1'b0;
  int   recv_wait   = 0;
  bit   recv_fast   = 1'b0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  int   results_seen = 0;
  int   error_count  = 0;
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned windows_now();
    int unsigned w;
    w = cfg_breathe ? FADE_WINDOWS_DEF : FLASH_WINDOWS_DEF;
    return (w == 0) ? 1 : w;
  endfunction

  function automatic void restart_windows();
    int unsigned       w;
    int unsigned       p;
    longint unsigned   len;
    w = windows_now();
    p = cfg_period;
    if (p >= PERIOD_MAX) p = PERIOD_MAX;
    if (p <= PERIOD_MIN) p = PERIOD_MIN;
    p = p - (p % w);
    len = (longint'(TICK_HZ_DEF) * p) / (longint'(w) * MS_PER_S);
    win_len    = (len > LEN_MAX) ? LEN_MAX : int'(len);
    tick_count = 0;
    win_count  = 0;
    shift_q    = cfg_pattern;
  endfunction

  function automatic void model_reset();
    cfg_breathe = 1'b0;
    cfg_pattern = '0;
    cfg_period  = 16'(PERIOD_RESET);
    cfg_enable  = 1'b0;
    led_q       = 1'b0;
    restart_windows();
  endfunction

  function automatic void model_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BREATHE_MODE:  cfg_breathe = data[0];
      REG_FLASH_PATTERN: cfg_pattern = data;
      REG_PERIOD:        cfg_period  = data[15:0];
      REG_ENABLE:        cfg_enable  = data[0];
      default: return;
    endcase
    restart_windows();
  endfunction

  function automatic void predict_tick(logic adv);
    int unsigned w;
    int unsigned m;
    int unsigned duty;
    result_t     r;
    w = windows_now();
    if (cfg_enable && adv) begin
      if (cfg_breathe) begin
        m = (win_count < w) ? (w - 1 - win_count) : 0;
        if (win_count < m) m = win_count;
        duty  = (2 * m * win_len) / w;
        led_q = (tick_count < duty);
        tick_count++;
        if (tick_count >= win_len) begin
          tick_count = 0;
          win_count++;
          if (win_count >= w) win_count = 0;
        end
      end else begin
        tick_count++;
        if (tick_count >= win_len) begin
          tick_count = 0;
          led_q      = shift_q[0];
          shift_q    = shift_q >> 1;
          win_count++;
          if (win_count >= w) begin
            win_count = 0;
            shift_q   = cfg_pattern;
          end
        end
      end
    end
    r.led_level    = led_q;
    r.window_index = INDEX_W'(win_count);
    expected_leds.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    error_count++;
  endtask

  // Input side: present items from the queue with a random gap after each.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
        in_valid <= 1'b1;
        advance  <= tick_queue.pop_front();
        send_gap = send_fast ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) predict_tick(advance);
  end

  // Output side: a random stall, possibly none, before each item, plus one long hold to back up the block.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) recv_fast = !recv_fast;
        recv_wait = recv_fast ? 0 : $urandom_range(0, 11);
      end
      if (results_seen == LONG_HOLD_AT && !hold_done) begin
        hold_left = LONG_HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_leds.size() == 0) begin
        report_mismatch("unexpected item", led_level, 0);
      end else begin
        want = expected_leds.pop_front();
        if (led_level !== want.led_level)
          report_mismatch("led_level", led_level, want.led_level);
        if (window_index !== want.window_index)
          report_mismatch("window_index", window_index, want.window_index);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    model_write(idx, data);
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // Unused upper data bits carry noise.
  task automatic set_regs(logic breathe, logic [PATTERN_W-1:0] pat, logic [15:0] per,
                          logic en);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom();
    noise[0] = breathe;
    write_reg(REG_BREATHE_MODE, noise);
    write_reg(REG_FLASH_PATTERN, pat);
    noise = $urandom();
    noise[15:0] = per;
    write_reg(REG_PERIOD, noise);
    noise = $urandom();
    noise[0] = en;
    write_reg(REG_ENABLE, noise);
  endtask

  task automatic queue_ticks(int count, int pct_tick);
    @(posedge clk);
    for (int i = 0; i < count; i++)
      tick_queue.push_back($urandom_range(1, 100) <= pct_tick);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_leds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd499;
      2: return 16'd500;
      3: return 16'd501;
      4: return 16'd2999;
      5: return 16'd3000;
      6: return 16'd3001;
      7: return 16'hFFFF;
      8: return 16'($urandom_range(500, 700));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [PATTERN_W-1:0] pat;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    model_reset();

    // disabled after reset: ticks and no-ops change nothing
    @(posedge clk);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    drain();

    // breathe at the top period clamp, first window has zero duty
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_PERIOD, 32'hFFFF);
    write_reg(REG_BREATHE_MODE, 32'd1);
    @(posedge clk);
    tick_queue.push_back(1'b0);
    queue_ticks(4, 100);
    drain();

    // flash all ones at the bottom period clamp, cross the first window
    write_reg(REG_BREATHE_MODE, 32'd0);
    write_reg(REG_FLASH_PATTERN, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd0);
    queue_ticks(16, 100);
    drain();

    // long flash run through a full pattern reload
    set_regs(1'b0, $urandom(), 16'($urandom_range(0, 500)), 1'b1);
    queue_ticks(500, 98);
    drain();

    // long breathe run up the triangle
    set_regs(1'b1, $urandom(), 16'($urandom_range(0, 520)), 1'b1);
    queue_ticks(100, 95);
    drain();

    for (int i = 0; i < 4; i++) begin
      case (i % 3)
        0:       pat = '0;
        1:       pat = '1;
        default: pat = $urandom();
      endcase
      set_regs($urandom_range(0, 1), pat, pick_period(), $urandom_range(0, 4) != 0);
      queue_ticks(20, 80);
      drain();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
